[rtl/hk_pkg.sv]
// Shared constants for the 3D Hilbert key pipeline.
// No dependencies; used by hk_cell, hk_gray and hilbert_key_3d_top.
`timescale 1ns / 1ps
`default_nettype none

package hk_pkg;

  // Number of bit levels per coordinate and the fixed field widths.
  localparam int unsigned HK_LEVELS      = 20;
  localparam int unsigned HK_COORD_W     = 20;
  localparam int unsigned HK_KEY_W       = 63;
  localparam int unsigned HK_IN_TDATA_W  = 64;
  localparam int unsigned HK_OUT_TDATA_W = 64;
  localparam int unsigned HK_PADDR_W     = 3;
  localparam int unsigned HK_PDATA_W     = 32;

  // Word slots inside the three-word bundle carried along the chain.
  localparam int unsigned HK_X = 0;
  localparam int unsigned HK_Y = 1;
  localparam int unsigned HK_Z = 2;

  // Register index of the order control.
  localparam logic HK_REG_ORDER = 1'b0;

endpackage

`default_nettype wire

[rtl/hk_cell.sv]
// One bit level of the invert-or-exchange pass, with its own pipeline register.
// Depends on hk_pkg for the word slot indexes.
`timescale 1ns / 1ps
`default_nettype none

module hk_cell import hk_pkg::*; #(
  parameter int unsigned Width = HK_LEVELS + 1,
  parameter int unsigned Bit   = HK_LEVELS
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic [2:0][Width-1:0]   in_word_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic      [2:0][Width-1:0]   out_word_o
);

  localparam logic [Width-1:0] Low = Width'((64'd1 << Bit) - 64'd1);

  logic [2:0][Width-1:0] word_d, word_q;
  logic                  valid_q;
  logic [Width-1:0]      w0, w1, w2, d1, d2;

  // x is inverted below this bit when its own bit is set; each of y and z
  // either inverts x or exchanges its low bits with x.
  always_comb begin
    w0 = in_word_i[HK_X];
    w1 = in_word_i[HK_Y];
    w2 = in_word_i[HK_Z];
    d1 = '0;
    d2 = '0;
    if (w0[Bit]) begin
      w0 = w0 ^ Low;
    end
    if (w1[Bit]) begin
      w0 = w0 ^ Low;
    end else begin
      d1 = (w0 ^ w1) & Low;
      w0 = w0 ^ d1;
      w1 = w1 ^ d1;
    end
    if (w2[Bit]) begin
      w0 = w0 ^ Low;
    end else begin
      d2 = (w0 ^ w2) & Low;
      w0 = w0 ^ d2;
      w2 = w2 ^ d2;
    end
    word_d[HK_X] = w0;
    word_d[HK_Y] = w1;
    word_d[HK_Z] = w2;
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      word_q <= word_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

endmodule

`default_nettype wire

[rtl/hk_gray.sv]
// Gray encoding, prefix-parity correction and triplet packing, with the output register.
// Depends on hk_pkg for the word slot indexes.
`timescale 1ns / 1ps
`default_nettype none

module hk_gray import hk_pkg::*; #(
  parameter int unsigned Width = HK_LEVELS + 1
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    reversed_i,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic [2:0][Width-1:0]   in_word_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic      [3*Width-1:0]      out_key_o
);

  logic [Width-1:0]   g0, g1, g2, t;
  logic [Width-1:0]   h0, h1, h2;
  logic [3*Width-1:0] key_std, key_rev, key_d, key_q;
  logic               valid_q;

  assign g0 = in_word_i[HK_X];
  assign g1 = in_word_i[HK_Y] ^ g0;
  assign g2 = in_word_i[HK_Z] ^ g1;

  // Each bit of the correction is the parity of all z bits above it.
  always_comb begin
    for (int j = 0; j < Width; j++) begin
      t[j] = ^(g2 >> (j + 1));
    end
  end

  assign h0 = g0 ^ t;
  assign h1 = g1 ^ t;
  assign h2 = g2 ^ t;

  always_comb begin
    for (int b = 0; b < Width; b++) begin
      key_std[3*b +: 3]             = {h0[b], h1[b], h2[b]};
      key_rev[3*(Width-1-b) +: 3]   = {h0[b], h1[b], h2[b]};
    end
  end

  assign key_d      = reversed_i ? key_rev : key_std;
  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      key_q <= key_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_key_o   = key_q;

endmodule

`default_nettype wire

[rtl/hilbert_key_3d_top.sv]
// Top level of the 3D Hilbert key generator: input unpacking, the cell chain,
// the output stage and the APB register. Depends on hk_pkg, hk_cell and hk_gray.
`timescale 1ns / 1ps
`default_nettype none

// This block turns one point, given as three unsigned LEVELS-bit coordinates,
// into its 3D Hilbert curve index. The key holds LEVELS+1 three-bit groups,
// x in the top bit of each group, and the group for level zero is always zero.
// With reversed_order clear the coarsest level sits at the top of the key; with
// it set the group order is reversed, so level zero lands in bits 2..0. The key
// occupies the low 3*(LEVELS+1) bits of m_axis_tdata and the rest reads zero.
// The work is a chain of LEVELS identical cells, one per bit level from the
// coarsest down, each with its own register, followed by one stage that does
// the Gray encoding, the parity correction and the packing into a registered
// output. A new beat is taken every clock cycle while the output is not stalled;
// an accepted beat passes through each cell register, then the output register.
// Each stage stalls only while it is full and the stage after it is stalled,
// so empty stages keep filling while a finished key waits at the output.
// The order register lives at APB address 0 and should only be written while
// no beat is in flight.

module hilbert_key_3d_top import hk_pkg::*; #(
  parameter int unsigned LEVELS = HK_LEVELS
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // APB register port.
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [HK_PADDR_W-1:0]       paddr,
  input  wire logic [HK_PDATA_W-1:0]       pwdata,
  output logic      [HK_PDATA_W-1:0]       prdata,
  output logic                             pready,
  // Input stream.
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  // Fields from bit 0 up: x_coord[19:0], y_coord[39:20], z_coord[59:40], zero pad.
  input  wire logic [HK_IN_TDATA_W-1:0]    s_axis_tdata,
  // Output stream.
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  // Fields from bit 0 up: hilbert_key[62:0], zero pad.
  output logic      [HK_OUT_TDATA_W-1:0]   m_axis_tdata
);

  localparam int unsigned W    = LEVELS + 1;
  localparam int unsigned KeyW = 3 * W;

  // ---------------------------------------------------------------------------
  // Configuration register. The register index is the word address bit above
  // the byte offset; writes to any other index are dropped.
  // ---------------------------------------------------------------------------
  logic reversed_q;
  logic cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == HK_REG_ORDER);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reversed_q <= 1'b0;
    end else if (cfg_write) begin
      reversed_q <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == HK_REG_ORDER) ? HK_PDATA_W'(reversed_q) : '0;

  // ---------------------------------------------------------------------------
  // Cell chain. Each word is widened by a zero top bit, which is level zero.
  // Coordinate bits above LEVELS are dropped here.
  // ---------------------------------------------------------------------------
  logic [LEVELS:0]       vld;
  logic [LEVELS:0]       rdy;
  logic [2:0][W-1:0]     word [LEVELS+1];

  assign vld[0]        = s_axis_tvalid;
  assign s_axis_tready = rdy[0];

  assign word[0][HK_X] = {1'b0, s_axis_tdata[LEVELS-1:0]};
  assign word[0][HK_Y] = {1'b0, s_axis_tdata[HK_COORD_W +: LEVELS]};
  assign word[0][HK_Z] = {1'b0, s_axis_tdata[2*HK_COORD_W +: LEVELS]};

  for (genvar k = 0; k < LEVELS; k++) begin : g_cell
    hk_cell #(
      .Width (W),
      .Bit   (LEVELS - k)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (vld[k]),
      .in_ready_o  (rdy[k]),
      .in_word_i   (word[k]),
      .out_valid_o (vld[k+1]),
      .out_ready_i (rdy[k+1]),
      .out_word_o  (word[k+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Gray encoding, packing and the output register.
  // ---------------------------------------------------------------------------
  logic [KeyW-1:0] key;

  hk_gray #(
    .Width (W)
  ) u_gray (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .reversed_i  (reversed_q),
    .in_valid_i  (vld[LEVELS]),
    .in_ready_o  (rdy[LEVELS]),
    .in_word_i   (word[LEVELS]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_key_o   (key)
  );

  assign m_axis_tdata = HK_OUT_TDATA_W'(key);

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------

  // An empty first cell must always be able to take a beat.
  a_first_cell_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld[1] |-> s_axis_tready)
    else $error("input stalled with an empty first cell");

  // The order register changes only on a write to its address.
  a_order_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_write |=> $stable(reversed_q))
    else $error("order register changed without a write");

  // The level zero group is zero in standard order, at the top of the key.
  a_level0_std: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !reversed_q) |-> (m_axis_tdata[KeyW-1 -: 3] == 3'b000))
    else $error("level zero group not zero in standard order");

  // The level zero group is zero in reversed order, at the bottom of the key.
  a_level0_rev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && reversed_q) |-> (m_axis_tdata[2:0] == 3'b000))
    else $error("level zero group not zero in reversed order");

  // Nothing is ever driven above the key.
  a_top_bit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[HK_OUT_TDATA_W-1] == 1'b0))
    else $error("output padding bit set");

endmodule

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for hilbert_key_3d_top: stream beats in, Hilbert keys out,
// and the order register over APB. Depends on hk_pkg and the RTL under rtl/.
`timescale 1ns / 1ps

module testbench;
  import hk_pkg::*;

  localparam int unsigned LEVELS = HK_LEVELS;
  localparam logic [HK_COORD_W-1:0] COORD_MAX = '1;

  // Register addresses: the order control and one unused index, which must be ignored.
  localparam int unsigned SPARE_REG_IDX = 1;
  localparam logic [HK_PADDR_W-1:0] ORDER_ADDR = HK_PADDR_W'(int'(HK_REG_ORDER) * 4);
  localparam logic [HK_PADDR_W-1:0] SPARE_ADDR = HK_PADDR_W'(SPARE_REG_IDX * 4);

  // Shapes of random coordinates, so that both sparse and dense bit patterns show up.
  typedef enum int unsigned {
    CK_UNIFORM, CK_TINY, CK_NEAR_TOP, CK_ONE_BIT, CK_WIDE
  } coord_kind_e;

  typedef struct {
    logic [HK_COORD_W-1:0] x;
    logic [HK_COORD_W-1:0] y;
    logic [HK_COORD_W-1:0] z;
    logic [HK_KEY_W-1:0]   key;
  } point_key_t;

  // The tracker keeps its own copy of the order register, computes the key of every
  // accepted point and holds the keys still owed by the block, oldest first.
  class key_tracker;
    bit           reversed;
    int unsigned  errors;
    point_key_t   keys_due[$];

    function new();
      reversed = 1'b0;
      errors   = 0;
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      errors++;
    endtask

    // Transposed Hilbert index: invert-or-exchange over each level from the coarsest
    // down, then Gray encoding with the parity correction, then triplet packing.
    function automatic logic [HK_KEY_W-1:0] hilbert_index(
        logic [HK_COORD_W-1:0] x, logic [HK_COORD_W-1:0] y, logic [HK_COORD_W-1:0] z,
        bit rev);
      logic [LEVELS:0]     w [3];
      logic [LEVELS:0]     low;
      logic [LEVELS:0]     d;
      logic [LEVELS:0]     fix;
      logic [HK_KEY_W-1:0] key;
      logic [2:0]          trip;
      int                  b;
      int                  i;
      int                  k;
      w[0] = {1'b0, x[LEVELS-1:0]};
      w[1] = {1'b0, y[LEVELS-1:0]};
      w[2] = {1'b0, z[LEVELS-1:0]};
      for (b = LEVELS; b > 0; b--) begin
        low = ((LEVELS+1)'(1) << b) - 1'b1;
        if (w[0][b]) w[0] ^= low;
        for (i = 1; i < 3; i++) begin
          if (w[i][b]) begin
            w[0] ^= low;
          end else begin
            d = (w[0] ^ w[i]) & low;
            w[0] ^= d;
            w[i] ^= d;
          end
        end
      end
      w[1] ^= w[0];
      w[2] ^= w[1];
      fix = '0;
      for (b = LEVELS; b > 0; b--) begin
        if (w[2][b]) fix ^= ((LEVELS+1)'(1) << b) - 1'b1;
      end
      for (i = 0; i < 3; i++) w[i] ^= fix;
      key = '0;
      for (k = 0; k <= LEVELS; k++) begin
        trip = {w[0][LEVELS-k], w[1][LEVELS-k], w[2][LEVELS-k]};
        if (rev) key[3*k +: 3] = trip;
        else key = {key[HK_KEY_W-4:0], trip};
      end
      return key;
    endfunction

    function void note_write(logic [HK_PADDR_W-1:0] addr, logic [HK_PDATA_W-1:0] data);
      if ((addr >> 2) == HK_REG_ORDER) reversed = data[0];
    endfunction

    function void note_point(logic [HK_COORD_W-1:0] x, logic [HK_COORD_W-1:0] y,
                             logic [HK_COORD_W-1:0] z);
      point_key_t p;
      p.x = x;
      p.y = y;
      p.z = z;
      p.key = hilbert_index(x, y, z, reversed);
      keys_due.push_back(p);
    endfunction

    task check_key(logic [HK_OUT_TDATA_W-1:0] tdata);
      point_key_t p;
      if (keys_due.size() == 0) begin
        report($sformatf("key beat %h arrived with no point outstanding", tdata));
      end else begin
        p = keys_due.pop_front();
        if (tdata[HK_KEY_W-1:0] !== p.key)
          report($sformatf("point (%h,%h,%h): key %h, predicted %h",
                           p.x, p.y, p.z, tdata[HK_KEY_W-1:0], p.key));
        if (tdata[HK_OUT_TDATA_W-1:HK_KEY_W] !== '0)
          report($sformatf("point (%h,%h,%h): pad bits of tdata not zero: %h",
                           p.x, p.y, p.z, tdata));
      end
    endtask

    function int unsigned outstanding();
      return keys_due.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [HK_PADDR_W-1:0]     paddr = '0;
  logic [HK_PDATA_W-1:0]     pwdata = '0;
  logic [HK_PDATA_W-1:0]     prdata;
  logic                      pready;

  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  // Fields from bit 0 up: x_coord[19:0], y_coord[39:20], z_coord[59:40], zero pad.
  logic [HK_IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  // Fields from bit 0 up: hilbert_key[62:0], zero pad.
  logic [HK_OUT_TDATA_W-1:0] m_axis_tdata;

  key_tracker tracker = new();

  // With calm set neither side idles, so with no hold-off it runs one beat per cycle.
  bit          calm = 1'b0;
  // A nonzero value asks the key sink to hold off that many cycles in one stretch.
  int unsigned hold_cycles = 0;

  hilbert_key_3d_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #10 clk_i = ~clk_i;

  // Hard limit well above the slowest legal run, with every gap and stall at its
  // longest, plus the long hold-offs and drains.
  initial begin
    #5ms;
    $display("** hilbert_key_3d_top: FAILED **");
    $finish;
  end

  // Key sink. Before each beat it draws a random stall, unless the run is calm or a
  // long hold-off was asked for. Outputs are sampled right after the edge, so the
  // values seen are the ones the block presented at that edge.
  initial begin : key_sink
    int unsigned stall;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 5);
      if (hold_cycles > 0) begin
        stall = hold_cycles;
        hold_cycles = 0;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      tracker.check_key(m_axis_tdata);
    end
  end

  // Offers one point. A gap drops tvalid first; with no gap tvalid stays high and only
  // the data changes, so each signal gets a single assignment per edge.
  task automatic send_point(input logic [HK_COORD_W-1:0] x, input logic [HK_COORD_W-1:0] y,
                            input logic [HK_COORD_W-1:0] z);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(HK_IN_TDATA_W - 3*HK_COORD_W){1'b0}}, z, y, x};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    tracker.note_point(x, y, z);
  endtask

  task automatic stop_sending();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Lets every owed key come out before the caller goes on.
  task automatic drain_keys();
    while (tracker.outstanding() > 0) @(posedge clk_i);
  endtask

  // The bus goes idle after each transfer, so a following transfer starts on a fresh edge.
  task automatic apb_write(input logic [HK_PADDR_W-1:0] addr,
                           input logic [HK_PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    tracker.note_write(addr, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Reads the order register back and compares it with the tracker's copy.
  task automatic apb_check_order();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ORDER_ADDR;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== HK_PDATA_W'(tracker.reversed))
      tracker.report($sformatf("order register read %h, expected %0d",
                               prdata, tracker.reversed));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [HK_COORD_W-1:0] pick_coord(coord_kind_e kind);
    logic [HK_COORD_W-1:0] v;
    case (kind)
      CK_TINY:     v = HK_COORD_W'($urandom_range(0, 15));
      CK_NEAR_TOP: v = COORD_MAX ^ HK_COORD_W'($urandom_range(0, 15));
      CK_ONE_BIT:  v = HK_COORD_W'(1) << $urandom_range(0, HK_COORD_W - 1);
      CK_WIDE:     v = HK_COORD_W'($urandom) | (HK_COORD_W'(1) << (HK_COORD_W - 1));
      default:     v = HK_COORD_W'($urandom);
    endcase
    return v;
  endfunction

  // Random points: mostly uniform, with some of each special shape and some points on
  // the diagonal, where the exchange steps all take the same branch.
  task automatic send_random(input int unsigned count);
    logic [HK_COORD_W-1:0] x;
    logic [HK_COORD_W-1:0] y;
    logic [HK_COORD_W-1:0] z;
    int unsigned n;
    for (n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) < 5) begin
        x = pick_coord(CK_UNIFORM);
        y = pick_coord(CK_UNIFORM);
        z = pick_coord(CK_UNIFORM);
      end else begin
        x = pick_coord(coord_kind_e'($urandom_range(0, 4)));
        y = pick_coord(coord_kind_e'($urandom_range(0, 4)));
        z = pick_coord(coord_kind_e'($urandom_range(0, 4)));
      end
      if ($urandom_range(0, 15) == 0) begin
        y = x;
        z = x;
      end
      send_point(x, y, z);
    end
  endtask

  // Directed points: the corners of the cube, each axis alone at its top and lowest
  // bit, checkerboard patterns and the diagonal.
  task automatic send_directed();
    send_point('0, '0, '0);
    send_point(COORD_MAX, COORD_MAX, COORD_MAX);
    send_point(COORD_MAX, '0, '0);
    send_point('0, COORD_MAX, '0);
    send_point('0, '0, COORD_MAX);
    send_point(COORD_MAX, COORD_MAX, '0);
    send_point('0, COORD_MAX, COORD_MAX);
    send_point(20'h00001, '0, '0);
    send_point('0, 20'h00001, '0);
    send_point('0, '0, 20'h00001);
    send_point(20'h80000, '0, '0);
    send_point('0, 20'h80000, '0);
    send_point('0, '0, 20'h80000);
    send_point(20'h80000, 20'h80000, 20'h80000);
    send_point(20'h55555, 20'haaaaa, 20'h55555);
    send_point(20'haaaaa, 20'h55555, 20'haaaaa);
    send_point(20'h12345, 20'h12345, 20'h12345);
    send_point(20'h7ffff, 20'h7ffff, 20'h7ffff);
    send_point(20'hfffff, 20'h00000, 20'hfffff);
    send_point(20'h0f0f0, 20'hf0f0f, 20'h33333);
  endtask

  initial begin : stimulus
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset value of the order register, then directed and random points, standard order.
    apb_check_order();
    send_directed();
    send_random(150);
    stop_sending();
    drain_keys();

    // Reversed order, written with every upper bit set; those bits must be ignored.
    // A write to the unused index must leave the order alone.
    apb_write(ORDER_ADDR, 32'hffff_ffff);
    apb_check_order();
    apb_write(SPARE_ADDR, 32'h0000_0000);
    apb_check_order();
    send_random(150);
    // The sink holds off far longer than the pipeline is deep while points keep
    // coming, so the block fills up and has to stall its input.
    calm = 1'b1;
    hold_cycles = 100;
    send_random(60);
    calm = 1'b0;
    send_random(100);
    stop_sending();
    drain_keys();

    // Standard order again, run back to back with no idling on either side. Halfway
    // through, the source pauses until the block has emptied.
    apb_write(ORDER_ADDR, 32'hffff_fffe);
    apb_check_order();
    calm = 1'b1;
    send_random(150);
    stop_sending();
    drain_keys();
    send_random(150);
    calm = 1'b0;
    stop_sending();
    drain_keys();

    apb_write(ORDER_ADDR, 32'h0000_0001);
    apb_check_order();
    send_random(300);
    stop_sending();
    drain_keys();

    // Back to standard order with only a stray upper bit in the written word.
    apb_write(ORDER_ADDR, 32'h0000_0002);
    apb_check_order();
    send_random(370);
    stop_sending();

    drain_keys();
    repeat (LEVELS + 10) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.outstanding() == 0) begin
      $display("** hilbert_key_3d_top: PASSED **");
    end else begin
      $display("** hilbert_key_3d_top: FAILED **");
    end
    $finish;
  end

endmodule

[hilbert_key_3d_top.f]
rtl/hk_pkg.sv
rtl/hk_cell.sv
rtl/hk_gray.sv
rtl/hilbert_key_3d_top.sv
tb/testbench.sv
